>>> sv/aarm_pkg.sv
package aarm_pkg;

	localparam int AX_W = 16;
	localparam int OUT_W = 16;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int MAX_STEPS = 32;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

	// Arctangent of 2^-i, with a full turn equal to 2^32.
	localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81,
		32'd41, 32'd20, 32'd10, 32'd5,
		32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [AX_W-1:0] axis_x;
		logic signed [AX_W-1:0] axis_y;
		logic signed [AX_W-1:0] axis_z;
		logic [15:0] angle;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] r00;
		logic signed [OUT_W-1:0] r01;
		logic signed [OUT_W-1:0] r02;
		logic signed [OUT_W-1:0] r10;
		logic signed [OUT_W-1:0] r11;
		logic signed [OUT_W-1:0] r12;
		logic signed [OUT_W-1:0] r20;
		logic signed [OUT_W-1:0] r21;
		logic signed [OUT_W-1:0] r22;
	} out_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic [1:0] quad;
		logic signed [AX_W-1:0] ax;
		logic signed [AX_W-1:0] ay;
		logic signed [AX_W-1:0] az;
	} cstage_t;

endpackage

>>> sv/aarm_stream_if.sv
interface aarm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/axis_angle_rotation_matrix_top.sv
// Axis-angle to 3x3 rotation matrix.
// The item channel is a sink carrying a Q1.14 unit axis and an angle in
// binary angle units; the result channel is a source carrying the nine
// matrix entries, row by row, in saturated Q1.14.
// A beat is taken on the item channel whenever valid and ready are both high,
// and the block can take one beat in every clock cycle while the result is not stalled.
// Each beat passes through one CORDIC cell per step and then four stages that
// form cosine and sine, the axis products, the scaled terms and the rounded
// and saturated sums; more than 32 steps asked for are capped at 32 cells.
// The whole pipeline advances together: when the result register holds a
// beat that the receiver has not taken, every stage holds and item ready
// drops in the same cycle, so no beat is lost or repeated.
// Asynchronous reset empties the pipeline; results in flight are dropped.
module axis_angle_rotation_matrix_top #(
	parameter int ANGLE_BITS = 16,
	parameter int COEF_FRAC_BITS = 14,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	aarm_stream_if.sink item,
	aarm_stream_if.source result
);

	localparam int NSTEPS =
		(CORDIC_STEPS > aarm_pkg::MAX_STEPS) ? aarm_pkg::MAX_STEPS : CORDIC_STEPS;
	localparam int PHASE_SH = 32 - ANGLE_BITS;

	logic en;
	logic res_vld;
	logic [31:0] phase;
	logic [NSTEPS:0] cvld;
	aarm_pkg::cstage_t cst [NSTEPS+1];
	aarm_pkg::out_t res_data;

	assign en = !res_vld || result.ready;
	assign item.ready = en;
	assign result.valid = res_vld;
	assign result.data = res_data;

	assign phase = 32'(item.data.angle) << PHASE_SH;

	always_comb begin
		cst[0].x = aarm_pkg::CORDIC_GAIN;
		cst[0].y = '0;
		cst[0].z = aarm_pkg::Z_W'({1'b0, phase[29:0]});
		cst[0].quad = phase[31:30];
		cst[0].ax = item.data.axis_x;
		cst[0].ay = item.data.axis_y;
		cst[0].az = item.data.axis_z;
	end
	assign cvld[0] = item.valid;

	for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
		aarm_cordic_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(cvld[g]),
			.d(cst[g]),
			.vld_q(cvld[g+1]),
			.q(cst[g+1])
		);
	end

	aarm_matrix #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_matrix (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(cvld[NSTEPS]),
		.d(cst[NSTEPS]),
		.vld_s4(res_vld),
		.r_s4(res_data)
	);

`ifndef SYNTH
	a_accept_enters_chain: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> cvld[1])
		else $error("accepted beat did not enter the first cell");

	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |=> $stable(cvld[NSTEPS:1]))
		else $error("pipeline moved while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !item.ready)
		else $error("item taken while result stalled");
`endif

endmodule

>>> sv/aarm_cordic_cell.sv
module aarm_cordic_cell #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input aarm_pkg::cstage_t d,
	output logic vld_q,
	output aarm_pkg::cstage_t q
);

	localparam logic signed [aarm_pkg::Z_W-1:0] ANG =
		$signed({1'b0, aarm_pkg::ATAN_TURNS[IDX]});

	logic signed [aarm_pkg::XY_W-1:0] dx;
	logic signed [aarm_pkg::XY_W-1:0] dy;
	aarm_pkg::cstage_t nxt;

	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		nxt = d;
		if (!d.z[aarm_pkg::Z_W-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ANG;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> sv/aarm_matrix.sv
module aarm_matrix #(
	parameter int COEF_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input aarm_pkg::cstage_t d,
	output logic vld_s4,
	output aarm_pkg::out_t r_s4
);

	localparam int F = COEF_FRAC_BITS;
	localparam int SH = 30 - F;
	localparam int RW = aarm_pkg::XY_W + 1;
	localparam int CW = F + 3;
	localparam int TW = F + 4;
	localparam int KKW = 2 * aarm_pkg::AX_W;
	localparam int PW = KKW + TW;
	localparam int PRW = PW + 1 - F;
	localparam int KW = aarm_pkg::AX_W + CW;
	localparam int CDW = CW + F;
	localparam int MW0 = (CDW > PRW) ? CDW : PRW;
	localparam int MW1 = (MW0 > KW) ? MW0 : KW;
	localparam int SW = MW1 + 2;
	localparam logic signed [RW-1:0] HALF_C = RW'((64'd1 << SH) >> 1);
	localparam logic signed [PW:0] HALF_P = (PW + 1)'(1) <<< (F - 1);
	localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (F - 1);

	localparam int KK_XX = 0;
	localparam int KK_YY = 1;
	localparam int KK_ZZ = 2;
	localparam int KK_XY = 3;
	localparam int KK_XZ = 4;
	localparam int KK_YZ = 5;
	localparam int NKK = 6;

	logic signed [RW-1:0] cr;
	logic signed [RW-1:0] sr;
	logic signed [RW-1:0] cr_rnd;
	logic signed [RW-1:0] sr_rnd;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;

	logic signed [CW-1:0] c_s1;
	logic signed [CW-1:0] s_s1;
	logic signed [TW-1:0] t_s1;
	logic signed [aarm_pkg::AX_W-1:0] ax_s1;
	logic signed [aarm_pkg::AX_W-1:0] ay_s1;
	logic signed [aarm_pkg::AX_W-1:0] az_s1;
	logic signed [KKW-1:0] kk_s1 [NKK];

	logic signed [PW-1:0] p_s2 [NKK];
	logic signed [KW-1:0] skx_s2;
	logic signed [KW-1:0] sky_s2;
	logic signed [KW-1:0] skz_s2;
	logic signed [CDW-1:0] cd_s2;

	logic signed [PW:0] p_half [NKK];
	logic signed [PRW-1:0] pr_s3 [NKK];
	logic signed [SW-1:0] skx_s3;
	logic signed [SW-1:0] sky_s3;
	logic signed [SW-1:0] skz_s3;
	logic signed [SW-1:0] cd_s3;

	aarm_pkg::out_t r_nxt;

	function automatic logic signed [aarm_pkg::OUT_W-1:0] round_sat(
		input logic signed [SW-1:0] v
	);
		logic signed [SW-1:0] sh;
		sh = (v + HALF_S) >>> F;
		if (sh > SW'(aarm_pkg::SAT_MAX)) begin
			return aarm_pkg::SAT_MAX;
		end else if (sh < SW'(aarm_pkg::SAT_MIN)) begin
			return aarm_pkg::SAT_MIN;
		end
		return aarm_pkg::OUT_W'(sh);
	endfunction

	always_comb begin
		unique case (d.quad)
			2'd0: begin
				cr = RW'(d.x);
				sr = RW'(d.y);
			end
			2'd1: begin
				cr = -RW'(d.y);
				sr = RW'(d.x);
			end
			2'd2: begin
				cr = -RW'(d.x);
				sr = -RW'(d.y);
			end
			default: begin
				cr = RW'(d.y);
				sr = -RW'(d.x);
			end
		endcase
		cr_rnd = (cr + HALF_C) >>> SH;
		sr_rnd = (sr + HALF_C) >>> SH;
	end

	always_comb begin
		for (int j = 0; j < NKK; j++) begin
			p_half[j] = (PW + 1)'(p_s2[j]) + HALF_P;
		end
	end

	always_comb begin
		r_nxt.r00 = round_sat(cd_s3 + SW'(pr_s3[KK_XX]));
		r_nxt.r01 = round_sat(SW'(pr_s3[KK_XY]) - skz_s3);
		r_nxt.r02 = round_sat(SW'(pr_s3[KK_XZ]) + sky_s3);
		r_nxt.r10 = round_sat(SW'(pr_s3[KK_XY]) + skz_s3);
		r_nxt.r11 = round_sat(cd_s3 + SW'(pr_s3[KK_YY]));
		r_nxt.r12 = round_sat(SW'(pr_s3[KK_YZ]) - skx_s3);
		r_nxt.r20 = round_sat(SW'(pr_s3[KK_XZ]) - sky_s3);
		r_nxt.r21 = round_sat(SW'(pr_s3[KK_YZ]) + skx_s3);
		r_nxt.r22 = round_sat(cd_s3 + SW'(pr_s3[KK_ZZ]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= CW'(cr_rnd);
			s_s1 <= CW'(sr_rnd);
			t_s1 <= (TW'(1) <<< F) - TW'(CW'(cr_rnd));
			ax_s1 <= d.ax;
			ay_s1 <= d.ay;
			az_s1 <= d.az;
			kk_s1[KK_XX] <= d.ax * d.ax;
			kk_s1[KK_YY] <= d.ay * d.ay;
			kk_s1[KK_ZZ] <= d.az * d.az;
			kk_s1[KK_XY] <= d.ax * d.ay;
			kk_s1[KK_XZ] <= d.ax * d.az;
			kk_s1[KK_YZ] <= d.ay * d.az;

			for (int j = 0; j < NKK; j++) begin
				p_s2[j] <= PW'(kk_s1[j]) * PW'(t_s1);
			end
			skx_s2 <= KW'(ax_s1) * KW'(s_s1);
			sky_s2 <= KW'(ay_s1) * KW'(s_s1);
			skz_s2 <= KW'(az_s1) * KW'(s_s1);
			cd_s2 <= CDW'(c_s1) <<< F;

			for (int j = 0; j < NKK; j++) begin
				pr_s3[j] <= PRW'(p_half[j] >>> F);
			end
			skx_s3 <= SW'(skx_s2);
			sky_s3 <= SW'(sky_s2);
			skz_s3 <= SW'(skz_s2);
			cd_s3 <= SW'(cd_s2);

			r_s4 <= r_nxt;
		end
	end

endmodule

>>> tb/axis_angle_rotation_matrix_top_tb.sv
module axis_angle_rotation_matrix_top_tb;

	localparam int ANGLE_BITS = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int RANDOM_ITEMS = 850;
	localparam int DRAIN_CYCLES = 2 * (CORDIC_STEPS + 4);
	localparam int LONG_HOLD = 200;
	localparam int LIMIT_CYCLES = 400000;
	localparam longint GAIN_Q30 = 64'sd652032874;

	localparam longint ARCTAN_STEP [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1, 0
	};

	typedef struct {
		aarm_pkg::in_t stim;
		bit typed;
		aarm_pkg::out_t want;
	} row_t;

	logic clk;
	logic arst_n;

	aarm_stream_if #(.T(aarm_pkg::in_t)) item_if ();
	aarm_stream_if #(.T(aarm_pkg::out_t)) res_if ();

	axis_angle_rotation_matrix_top #(
		.ANGLE_BITS(ANGLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(res_if)
	);

	aarm_pkg::out_t expected_matrices [$];
	row_t directed_rows [$];
	int errors = 0;
	int cycles = 0;
	bit hold_long = 1'b0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	aarm_pkg::out_t got_m;
	aarm_pkg::out_t want_m;
	string entry_names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

	function automatic longint round_q(input longint v, input int sh);
		if (sh == 0)
			return v;
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [15:0] matrix_entry(input longint diag, input longint ka,
			input longint kb, input longint t, input longint skew);
		longint prod;
		prod = round_q(ka * kb * t, COEF_FRAC_BITS);
		return clamp16(round_q(diag + skew + prod, COEF_FRAC_BITS));
	endfunction

	function automatic aarm_pkg::out_t rotation_matrix(input aarm_pkg::in_t v);
		longint kx, ky, kz, x, y, z, dx, dy, cr, sr, c, s, t, cd;
		logic [63:0] wide;
		logic [31:0] phase;
		aarm_pkg::out_t m;
		kx = longint'($signed(v.axis_x));
		ky = longint'($signed(v.axis_y));
		kz = longint'($signed(v.axis_z));
		wide = {48'b0, v.angle} & ((64'd1 << ANGLE_BITS) - 64'd1);
		phase = 32'(wide << (32 - ANGLE_BITS));
		x = GAIN_Q30;
		y = 0;
		z = longint'({34'b0, phase[29:0]});
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_STEP[i];
			end
		end
		case (phase[31:30])
			2'd0: begin
				cr = x;
				sr = y;
			end
			2'd1: begin
				cr = -y;
				sr = x;
			end
			2'd2: begin
				cr = -x;
				sr = -y;
			end
			default: begin
				cr = y;
				sr = -x;
			end
		endcase
		c = round_q(cr, 30 - COEF_FRAC_BITS);
		s = round_q(sr, 30 - COEF_FRAC_BITS);
		t = (longint'(1) <<< COEF_FRAC_BITS) - c;
		cd = c * (longint'(1) <<< COEF_FRAC_BITS);
		m.r00 = matrix_entry(cd, kx, kx, t, 0);
		m.r01 = matrix_entry(0, kx, ky, t, -kz * s);
		m.r02 = matrix_entry(0, kx, kz, t, ky * s);
		m.r10 = matrix_entry(0, kx, ky, t, kz * s);
		m.r11 = matrix_entry(cd, ky, ky, t, 0);
		m.r12 = matrix_entry(0, ky, kz, t, -kx * s);
		m.r20 = matrix_entry(0, kx, kz, t, -ky * s);
		m.r21 = matrix_entry(0, ky, kz, t, kx * s);
		m.r22 = matrix_entry(cd, kz, kz, t, 0);
		return m;
	endfunction

	task automatic add_row(input int ax, input int ay, input int az, input int ang,
			input bit typed, input aarm_pkg::out_t want);
		row_t r;
		r.stim.axis_x = ax[15:0];
		r.stim.axis_y = ay[15:0];
		r.stim.axis_z = az[15:0];
		r.stim.angle = ang[15:0];
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	// The expectation is queued at the edge where the beat is accepted.
	task automatic offer(input aarm_pkg::in_t stim, input bit typed,
			input aarm_pkg::out_t want, input int gap);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data <= stim;
		do @(posedge clk); while (!item_if.ready);
		expected_matrices.push_back(typed ? want : rotation_matrix(stim));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			got_m = res_if.data;
			if (expected_matrices.size() == 0) begin
				if (errors < 10)
					$display("unexpected result beat %h", got_m);
				errors++;
			end else begin
				want_m = expected_matrices.pop_front();
				for (int j = 0; j < 9; j++) begin
					if (got_m[(8 - j) * 16 +: 16] !== want_m[(8 - j) * 16 +: 16]) begin
						if (errors < 10)
							$display("%s mismatch: expected %0d, got %0d", entry_names[j],
								$signed(want_m[(8 - j) * 16 +: 16]),
								$signed(got_m[(8 - j) * 16 +: 16]));
						errors++;
					end
				end
			end
		end
	end

	initial begin : receiver
		int stall;
		res_if.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 9);
			if (hold_long) begin
				stall = LONG_HOLD;
				hold_long = 1'b0;
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	initial begin : stimulus
		aarm_pkg::in_t stim;
		real gx, gy, gz, len;
		int gap;
		aarm_pkg::out_t all_high;
		aarm_pkg::out_t checker_sat;
		all_high = {9{16'h7fff}};
		checker_sat = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
		arst_n <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.data <= '0;

		add_row(16384, 0, 0, 16'h0000, 1'b0, '0);
		add_row(0, 16384, 0, 16'h2000, 1'b0, '0);
		add_row(0, 0, 16384, 16'h4000, 1'b0, '0);
		add_row(16384, 0, 0, 16'h8000, 1'b0, '0);
		add_row(0, -16384, 0, 16'hC000, 1'b0, '0);
		add_row(0, 0, -16384, 16'hFFFF, 1'b0, '0);
		add_row(9459, 9459, 9459, 16'h0001, 1'b0, '0);
		add_row(9459, -9459, 9459, 16'h3FFF, 1'b0, '0);
		add_row(-9459, 9459, -9459, 16'h4001, 1'b0, '0);
		add_row(0, 0, 0, 16'h5555, 1'b0, '0);
		add_row(32767, 32767, 32767, 16'h8000, 1'b1, all_high);
		add_row(-32768, -32768, -32768, 16'h8000, 1'b1, all_high);
		add_row(-32768, 32767, -32768, 16'h8000, 1'b1, checker_sat);
		add_row(32767, -32768, 0, 16'h7FFF, 1'b0, '0);
		add_row(-32768, -32768, -32768, 16'h0000, 1'b0, '0);
		add_row(11585, 11585, 0, 16'hBFFF, 1'b0, '0);
		add_row(16384, 16384, 16384, 16'hC001, 1'b0, '0);
		add_row(-1, 1, -1, 16'hE000, 1'b0, '0);
		add_row(13377, -8192, 4096, 16'h1234, 1'b0, '0);
		add_row(32767, 32767, 32767, 16'h6000, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want,
				$urandom_range(0, 9));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Keep beats coming while the receiver holds off so the pipeline backs up.
			if (n == 200)
				hold_long = 1'b1;
			if (n == 500) begin
				item_if.valid <= 1'b0;
				while (expected_matrices.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 49) == 0) begin
				tx_burst = !tx_burst;
			end
			case ($urandom_range(0, 9))
				7, 8: begin
					stim.axis_x = 16'($urandom_range(0, 65535));
					stim.axis_y = 16'($urandom_range(0, 65535));
					stim.axis_z = 16'($urandom_range(0, 65535));
				end
				9: begin
					stim.axis_x = 16'(($urandom_range(0, 1) ? 16384 : -16384) * $urandom_range(0, 1));
					stim.axis_y = 16'(($urandom_range(0, 1) ? 16384 : -16384) * $urandom_range(0, 1));
					stim.axis_z = 16'(($urandom_range(0, 1) ? 16384 : -16384) * $urandom_range(0, 1));
				end
				default: begin
					gx = real'($urandom_range(0, 2000)) - 1000.0;
					gy = real'($urandom_range(0, 2000)) - 1000.0;
					gz = real'($urandom_range(0, 2000)) - 1000.0;
					len = $sqrt(gx * gx + gy * gy + gz * gz);
					if (len < 1.0) begin
						gx = 1000.0;
						len = 1000.0;
					end
					stim.axis_x = 16'(int'(gx * 16384.0 / len));
					stim.axis_y = 16'(int'(gy * 16384.0 / len));
					stim.axis_z = 16'(int'(gz * 16384.0 / len));
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				stim.angle = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
			else
				stim.angle = 16'($urandom_range(0, 65535));
			gap = (tx_burst || (n >= 200 && n < 260)) ? 0 : $urandom_range(0, 9);
			offer(stim, 1'b0, '0, gap);
		end
		item_if.valid <= 1'b0;

		while (expected_matrices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
